/* sv/tkd_pkg.sv */
// Shared constants and types for the terminal key decoder.
// No dependencies; imported by tkd_key_map and terminal_key_decoder_core.
package tkd_pkg;

    // Parameter bytes held per escape run is PARAM_BYTES-1
    localparam int PARAM_BYTES = 8;
    localparam int KEPT_W      = $clog2(PARAM_BYTES);

    localparam int CODE_W = 21;
    localparam int KEY_W  = 4;
    localparam int NUM_W  = 8;

    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] CSI_INTRO = 8'h5B; // '['
    localparam logic [7:0] SS3_INTRO = 8'h4F; // 'O'
    localparam logic [7:0] FINAL_LO  = 8'h40; // '@'
    localparam logic [7:0] FINAL_HI  = 8'h7E; // '~'
    localparam logic [7:0] SEMICOLON = 8'h3B;
    localparam logic [7:0] DIGIT_0   = 8'h30;
    localparam logic [7:0] DIGIT_9   = 8'h39;

    // Final bytes that name a key
    localparam logic [7:0] FIN_UP    = 8'h41; // 'A'
    localparam logic [7:0] FIN_DOWN  = 8'h42; // 'B'
    localparam logic [7:0] FIN_RIGHT = 8'h43; // 'C'
    localparam logic [7:0] FIN_LEFT  = 8'h44; // 'D'
    localparam logic [7:0] FIN_HOME  = 8'h48; // 'H'

    // Leading numbers ahead of '~'
    localparam logic [NUM_W-1:0] VT_HOME     = 8'd1;
    localparam logic [NUM_W-1:0] VT_INSERT   = 8'd2;
    localparam logic [NUM_W-1:0] VT_DELETE   = 8'd3;
    localparam logic [NUM_W-1:0] VT_PGUP     = 8'd5;
    localparam logic [NUM_W-1:0] VT_PGDOWN   = 8'd6;
    localparam logic [NUM_W-1:0] VT_HOME_ALT = 8'd7;

    // Number after ';' (modifier plus one)
    localparam logic [NUM_W-1:0] MODNUM_CTRL       = 8'd5;
    localparam logic [NUM_W-1:0] MODNUM_CTRL_SHIFT = 8'd6;

    // Special key indexes
    localparam logic [KEY_W-1:0] SPK_UP         = 4'd0;
    localparam logic [KEY_W-1:0] SPK_DOWN       = 4'd1;
    localparam logic [KEY_W-1:0] SPK_LEFT       = 4'd2;
    localparam logic [KEY_W-1:0] SPK_RIGHT      = 4'd3;
    localparam logic [KEY_W-1:0] SPK_CS_UP      = 4'd4;
    localparam logic [KEY_W-1:0] SPK_CS_DOWN    = 4'd5;
    localparam logic [KEY_W-1:0] SPK_CS_LEFT    = 4'd6;
    localparam logic [KEY_W-1:0] SPK_CS_RIGHT   = 4'd7;
    localparam logic [KEY_W-1:0] SPK_CTRL_LEFT  = 4'd8;
    localparam logic [KEY_W-1:0] SPK_CTRL_RIGHT = 4'd9;
    localparam logic [KEY_W-1:0] SPK_DEL        = 4'd10;
    localparam logic [KEY_W-1:0] SPK_HOME       = 4'd11;
    localparam logic [KEY_W-1:0] SPK_PGUP       = 4'd12;
    localparam logic [KEY_W-1:0] SPK_PGDN       = 4'd13;

    // Parameter run summary handed to the key map
    typedef struct packed {
        logic [NUM_W-1:0] lead_num;
        logic             semi_seen;
        logic [NUM_W-1:0] mod_num;
    } t_csi_params;

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] idx;
    } t_key_res;

endpackage

/* sv/terminal_key_decoder_core.sv */
// Terminal key decoder: UTF-8 assembly and CSI/SS3 escape decoding.
// A key appears on the master side in the cycle after the beat that completes it is accepted.
// The decoder takes 1 beat per cycle unless the output stalls; the decode state updates on each accepted beat.
// The output register takes a new beat whenever it is empty or being drained.
// Reset (synchronous, active low) returns the parser to idle and empties the output.
// Depends on tkd_pkg and tkd_key_map.
module terminal_key_decoder_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // [7:0] byte_req
    input  logic                      s_axis_tuser,  // [0] mode (1 = timeout)
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [23:0]               m_axis_tdata,  // [20:0] code, [23:21] zero
    output logic                      m_axis_tuser   // [0] is_special
);
    import tkd_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_UTF8, PH_ESC, PH_PARAMS} t_phase;

    t_phase              r_phase, n_phase;
    logic [7:0]          r_lead, n_lead;
    logic [1:0]          r_rem, n_rem;
    logic [CODE_W-1:0]   r_accum, n_accum;
    logic                r_bad, n_bad;
    logic [KEPT_W-1:0]   r_kept, n_kept;
    logic [NUM_W-1:0]    r_lead_num, n_lead_num;
    logic                r_lead_done, n_lead_done;
    logic                r_semi, n_semi;
    logic [NUM_W-1:0]    r_mod_num, n_mod_num;
    logic                r_mod_done, n_mod_done;

    logic                r_out_valid;
    logic                r_out_special, n_out_special;
    logic [CODE_W-1:0]   r_out_code, n_out_code;
    logic                n_emit;

    logic                accept;
    logic                timeout;
    logic [7:0]          b;
    logic                is_digit;
    t_csi_params         csi;
    t_key_res            key;

    function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] v,
                                                   input logic [7:0] ch);
        logic [11:0] r;
        r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'h00, ch[3:0]};
        return (r > 12'd255) ? 8'd255 : r[7:0];
    endfunction

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign timeout       = s_axis_tuser;
    assign b             = s_axis_tdata;
    assign is_digit      = (b >= DIGIT_0) && (b <= DIGIT_9);

    assign csi.lead_num  = r_lead_num;
    assign csi.semi_seen = r_semi;
    assign csi.mod_num   = r_mod_num;

    tkd_key_map u_key_map (
        .i_final  (b),
        .i_params (csi),
        .o_key    (key)
    );

    always_comb begin
        n_phase       = r_phase;
        n_lead        = r_lead;
        n_rem         = r_rem;
        n_accum       = r_accum;
        n_bad         = r_bad;
        n_kept        = r_kept;
        n_lead_num    = r_lead_num;
        n_lead_done   = r_lead_done;
        n_semi        = r_semi;
        n_mod_num     = r_mod_num;
        n_mod_done    = r_mod_done;
        n_emit        = 1'b0;
        n_out_special = 1'b0;
        n_out_code    = {{(CODE_W-8){1'b0}}, ESC_BYTE};
        case (r_phase)
            PH_UTF8: begin
                if (timeout) begin
                    n_phase    = PH_IDLE;
                    n_emit     = 1'b1;
                    n_out_code = {{(CODE_W-8){1'b0}}, r_lead};
                end else begin
                    n_bad   = r_bad || (b[7:6] != 2'b10);
                    n_accum = {r_accum[CODE_W-7:0], b[5:0]};
                    n_rem   = r_rem - 2'd1;
                    if (r_rem == 2'd1) begin
                        n_phase    = PH_IDLE;
                        n_emit     = 1'b1;
                        n_out_code = n_bad ? {{(CODE_W-8){1'b0}}, r_lead} : n_accum;
                    end
                end
            end
            PH_ESC: begin
                if (!timeout && (b == CSI_INTRO || b == SS3_INTRO)) begin
                    n_phase     = PH_PARAMS;
                    n_kept      = '0;
                    n_lead_num  = '0;
                    n_lead_done = 1'b0;
                    n_semi      = 1'b0;
                    n_mod_num   = '0;
                    n_mod_done  = 1'b0;
                end else begin
                    n_phase = PH_IDLE;
                    n_emit  = 1'b1;
                end
            end
            PH_PARAMS: begin
                if (timeout) begin
                    n_phase = PH_IDLE;
                    n_emit  = 1'b1;
                end else if (b >= FINAL_LO && b <= FINAL_HI) begin
                    n_phase = PH_IDLE;
                    n_emit  = 1'b1;
                    if (key.hit) begin
                        n_out_special = 1'b1;
                        n_out_code    = {{(CODE_W-KEY_W){1'b0}}, key.idx};
                    end
                end else if (r_kept < KEPT_W'(PARAM_BYTES - 1)) begin
                    // bytes past the kept limit are swallowed
                    n_kept = r_kept + KEPT_W'(1);
                    if (!r_lead_done) begin
                        if (is_digit) n_lead_num = add_digit(r_lead_num, b);
                        else          n_lead_done = 1'b1;
                    end
                    if (r_semi) begin
                        if (!r_mod_done) begin
                            if (is_digit) n_mod_num = add_digit(r_mod_num, b);
                            else          n_mod_done = 1'b1;
                        end
                    end else if (b == SEMICOLON) begin
                        n_semi = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (!timeout) begin
                    if (b == ESC_BYTE) begin
                        n_phase = PH_ESC;
                    end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110
                                 || b[7:3] == 5'b11110) begin
                        n_lead  = b;
                        n_bad   = 1'b0;
                        n_phase = PH_UTF8;
                        if (b[7:5] == 3'b110) begin
                            n_rem   = 2'd1;
                            n_accum = {{(CODE_W-5){1'b0}}, b[4:0]};
                        end else if (b[7:4] == 4'b1110) begin
                            n_rem   = 2'd2;
                            n_accum = {{(CODE_W-4){1'b0}}, b[3:0]};
                        end else begin
                            n_rem   = 2'd3;
                            n_accum = {{(CODE_W-3){1'b0}}, b[2:0]};
                        end
                    end else begin
                        // ASCII and stray bytes go straight out
                        n_emit     = 1'b1;
                        n_out_code = {{(CODE_W-8){1'b0}}, b};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_out_valid <= n_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_lead      <= n_lead;
            r_rem       <= n_rem;
            r_accum     <= n_accum;
            r_bad       <= n_bad;
            r_kept      <= n_kept;
            r_lead_num  <= n_lead_num;
            r_lead_done <= n_lead_done;
            r_semi      <= n_semi;
            r_mod_num   <= n_mod_num;
            r_mod_done  <= n_mod_done;
            if (n_emit) begin
                r_out_special <= n_out_special;
                r_out_code    <= n_out_code;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_special;
    assign m_axis_tdata  = {{(24-CODE_W){1'b0}}, r_out_code};

    a_utf8_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_UTF8) |-> (r_rem != 2'd0))
        else $error("UTF-8 collection with no continuation pending");

    a_kept_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PARAMS) |-> (r_kept <= KEPT_W'(PARAM_BYTES - 1)))
        else $error("parameter byte count beyond limit");

    a_special_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_special) |-> (r_out_code <= CODE_W'(SPK_PGDN)))
        else $error("special key index out of range");

    a_ascii_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_IDLE && !s_axis_tuser && !s_axis_tdata[7]
         && s_axis_tdata != ESC_BYTE)
        |=> (r_out_valid && !r_out_special
             && r_out_code == {{(CODE_W-8){1'b0}}, $past(s_axis_tdata)}))
        else $error("ASCII beat not passed through");

endmodule

/* sv/tkd_key_map.sv */
// Maps the final byte of a CSI/SS3 run plus its parsed numbers to a key index.
// Depends on tkd_pkg.
module tkd_key_map (
    input  logic [7:0]           i_final,
    input  tkd_pkg::t_csi_params i_params,
    output tkd_pkg::t_key_res    o_key
);
    import tkd_pkg::*;

    logic is_cs;
    logic is_ctrl;

    // modifier = number - 1: ctrl-shift is 6, ctrl is 5 after the ';'
    assign is_cs   = i_params.semi_seen && (i_params.mod_num == MODNUM_CTRL_SHIFT);
    assign is_ctrl = i_params.semi_seen && (i_params.mod_num == MODNUM_CTRL);

    always_comb begin
        o_key.hit = 1'b1;
        o_key.idx = SPK_UP;
        case (i_final)
            FIN_UP:    o_key.idx = is_cs ? SPK_CS_UP : SPK_UP;
            FIN_DOWN:  o_key.idx = is_cs ? SPK_CS_DOWN : SPK_DOWN;
            FIN_RIGHT: o_key.idx = is_cs ? SPK_CS_RIGHT
                                         : (is_ctrl ? SPK_CTRL_RIGHT : SPK_RIGHT);
            FIN_LEFT:  o_key.idx = is_cs ? SPK_CS_LEFT
                                         : (is_ctrl ? SPK_CTRL_LEFT : SPK_LEFT);
            FIN_HOME:  o_key.idx = SPK_HOME;
            FINAL_HI: begin
                case (i_params.lead_num)
                    VT_HOME:     o_key.idx = SPK_HOME;
                    VT_DELETE:   o_key.idx = SPK_DEL;
                    VT_PGUP:     o_key.idx = SPK_PGUP;
                    VT_PGDOWN:   o_key.idx = SPK_PGDN;
                    VT_HOME_ALT: o_key.idx = SPK_HOME;
                    default:     o_key.hit = 1'b0;
                endcase
            end
            default: o_key.hit = 1'b0;
        endcase
    end

endmodule

/* verif/tb_terminal_key_decoder_core.sv */
// Self-checking bench for terminal_key_decoder_core: byte and timeout beats in,
// decoded keys out, compared in order against a cycle-free key predictor.
// Depends on tkd_pkg and the terminal_key_decoder_core RTL.
module tb_terminal_key_decoder_core;
    import tkd_pkg::*;

    localparam int RANDOM_BEATS = 1150;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    // Modifier after ';' is the number minus one
    localparam int MODIF_CTRL       = 4;
    localparam int MODIF_CTRL_SHIFT = 5;

    localparam logic [7:0] FIN_TILDE = FINAL_HI;

    typedef enum logic [1:0] {ST_IDLE, ST_UTF8, ST_ESC, ST_PARAMS} t_dec_state;

    typedef struct packed {
        logic       tmo;
        logic [7:0] data;
    } t_beat;

    typedef struct packed {
        logic              special;
        logic [CODE_W-1:0] code;
    } t_key;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [7:0] byte_req
    logic              s_axis_tuser = 1'b0; // [0] mode
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;        // [20:0] code, [23:21] zero
    logic              m_axis_tuser;        // [0] is_special

    t_beat byte_feed[$];
    t_key  pending_keys[$];

    int n_beats;
    int beats_sent;
    int send_idle_pct = 33;
    int recv_stall_pct = 81;
    int bad_beats;
    int quiet_cycles;

    // predictor state
    t_dec_state        dec_state = ST_IDLE;
    logic [7:0]        u_lead = '0;
    logic [1:0]        u_left = '0;
    logic [CODE_W-1:0] u_accum = '0;
    logic              u_bad = 1'b0;
    int                p_kept;
    logic [7:0]        p_lead = '0;
    logic              p_lead_done = 1'b0;
    logic              p_semi = 1'b0;
    logic [7:0]        p_mod = '0;
    logic              p_mod_done = 1'b0;

    terminal_key_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- key predictor ----------------

    function automatic void push_key(logic special, logic [CODE_W-1:0] code);
        pending_keys.push_back({special, code});
    endfunction

    function automatic logic [7:0] sat_digit(logic [7:0] v, logic [7:0] ch);
        int r;
        r = int'(v) * 10 + int'(ch - DIGIT_0);
        return (r > 255) ? 8'hFF : 8'(r);
    endfunction

    function automatic void keep_param(logic [7:0] b);
        logic digit;
        digit = (b >= DIGIT_0) && (b <= DIGIT_9);
        if (p_kept < PARAM_BYTES - 1) begin
            p_kept++;
            if (!p_lead_done) begin
                if (digit) p_lead = sat_digit(p_lead, b);
                else p_lead_done = 1'b1;
            end
            if (p_semi) begin
                if (!p_mod_done) begin
                    if (digit) p_mod = sat_digit(p_mod, b);
                    else p_mod_done = 1'b1;
                end
            end else if (b == SEMICOLON) begin
                p_semi = 1'b1;
            end
        end
    endfunction

    // Special key for a final byte, -1 when it names nothing
    function automatic int final_key(logic [7:0] f);
        int mod_val;
        mod_val = (p_semi && p_mod >= 1) ? int'(p_mod) - 1 : 0;
        case (f)
            FIN_UP:    return (mod_val == MODIF_CTRL_SHIFT) ? SPK_CS_UP : SPK_UP;
            FIN_DOWN:  return (mod_val == MODIF_CTRL_SHIFT) ? SPK_CS_DOWN : SPK_DOWN;
            FIN_RIGHT: return (mod_val == MODIF_CTRL_SHIFT) ? SPK_CS_RIGHT :
                              (mod_val == MODIF_CTRL) ? SPK_CTRL_RIGHT : SPK_RIGHT;
            FIN_LEFT:  return (mod_val == MODIF_CTRL_SHIFT) ? SPK_CS_LEFT :
                              (mod_val == MODIF_CTRL) ? SPK_CTRL_LEFT : SPK_LEFT;
            FIN_HOME:  return SPK_HOME;
            FIN_TILDE: begin
                case (int'(p_lead))
                    VT_HOME, VT_HOME_ALT: return SPK_HOME;
                    VT_DELETE:            return SPK_DEL;
                    VT_PGUP:              return SPK_PGUP;
                    VT_PGDOWN:            return SPK_PGDN;
                    default:              return -1;
                endcase
            end
            default: return -1;
        endcase
    endfunction

    function automatic void start_utf8(logic [7:0] b, logic [1:0] left,
                                       logic [CODE_W-1:0] bits);
        u_lead    = b;
        u_left    = left;
        u_accum   = bits;
        u_bad     = 1'b0;
        dec_state = ST_UTF8;
    endfunction

    function automatic void decode_beat(logic tmo, logic [7:0] b);
        int k;
        case (dec_state)
            ST_UTF8: begin
                if (tmo) begin
                    dec_state = ST_IDLE;
                    push_key(1'b0, CODE_W'(u_lead));
                end else begin
                    if (b[7:6] != 2'b10) u_bad = 1'b1;
                    u_accum = {u_accum[CODE_W-7:0], b[5:0]};
                    u_left  = u_left - 2'd1;
                    if (u_left == 2'd0) begin
                        dec_state = ST_IDLE;
                        push_key(1'b0, u_bad ? CODE_W'(u_lead) : u_accum);
                    end
                end
            end
            ST_ESC: begin
                if (!tmo && (b == CSI_INTRO || b == SS3_INTRO)) begin
                    p_kept      = 0;
                    p_lead      = '0;
                    p_lead_done = 1'b0;
                    p_semi      = 1'b0;
                    p_mod       = '0;
                    p_mod_done  = 1'b0;
                    dec_state   = ST_PARAMS;
                end else begin
                    dec_state = ST_IDLE;
                    push_key(1'b0, CODE_W'(ESC_BYTE));
                end
            end
            ST_PARAMS: begin
                if (tmo) begin
                    dec_state = ST_IDLE;
                    push_key(1'b0, CODE_W'(ESC_BYTE));
                end else if (b >= FINAL_LO && b <= FINAL_HI) begin
                    k = final_key(b);
                    dec_state = ST_IDLE;
                    if (k < 0) push_key(1'b0, CODE_W'(ESC_BYTE));
                    else push_key(1'b1, CODE_W'(k));
                end else begin
                    keep_param(b);
                end
            end
            default: begin
                dec_state = ST_IDLE;
                if (!tmo) begin
                    if (b == ESC_BYTE) dec_state = ST_ESC;
                    else if (b < 8'h80) push_key(1'b0, CODE_W'(b));
                    else if (b[7:5] == 3'b110) start_utf8(b, 2'd1, CODE_W'(b[4:0]));
                    else if (b[7:4] == 4'b1110) start_utf8(b, 2'd2, CODE_W'(b[3:0]));
                    else if (b[7:3] == 5'b11110) start_utf8(b, 2'd3, CODE_W'(b[2:0]));
                    else push_key(1'b0, CODE_W'(b));
                end
            end
        endcase
    endfunction

    // ---------------- stimulus ----------------

    function automatic void put_byte(logic [7:0] b);
        byte_feed.push_back('{tmo: 1'b0, data: b});
    endfunction

    // byte field is don't-care on a timeout, so keep it random
    function automatic void put_tmo();
        byte_feed.push_back('{tmo: 1'b1, data: 8'($urandom)});
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // len 2..4; corrupt swaps one continuation for a non-10xxxxxx byte,
    // cut stops early with a timeout
    function automatic void add_utf8(int len, bit corrupt, bit cut);
        int bad_at;
        int stop_at;
        logic [7:0] b;
        case (len)
            2:       put_byte({3'b110, 5'($urandom)});
            3:       put_byte({4'b1110, 4'($urandom)});
            default: put_byte({5'b11110, 3'($urandom)});
        endcase
        bad_at  = corrupt ? $urandom_range(len - 2) : -1;
        stop_at = cut ? $urandom_range(len - 2) : len - 1;
        for (int i = 0; i < stop_at; i++) begin
            if (i == bad_at) begin
                do b = 8'($urandom); while (b[7:6] == 2'b10);
                put_byte(b);
            end else begin
                put_byte(cont_byte());
            end
        end
        if (cut) put_tmo();
    endfunction

    function automatic int pick_lead();
        int vt_nums[6];
        vt_nums = '{VT_HOME, VT_INSERT, VT_DELETE, VT_PGUP, VT_PGDOWN, VT_HOME_ALT};
        case ($urandom_range(3))
            0, 1:    return vt_nums[$urandom_range(5)];
            2:       return $urandom_range(9);
            default: return $urandom_range(999);
        endcase
    endfunction

    function automatic void add_esc_run(bit cut);
        int form;
        int len;
        logic [7:0] b;
        logic [7:0] finals[6];
        finals = '{FIN_UP, FIN_DOWN, FIN_RIGHT, FIN_LEFT, FIN_HOME, FIN_TILDE};
        put_byte(ESC_BYTE);
        put_byte($urandom_range(1) ? CSI_INTRO : SS3_INTRO);
        form = $urandom_range(9);
        if (form >= 2 && form <= 4) begin
            put_text($sformatf("%0d", pick_lead()));
        end else if (form >= 5 && form <= 7) begin
            if ($urandom_range(4) != 0) put_text($sformatf("%0d", pick_lead()));
            put_byte(SEMICOLON);
            case ($urandom_range(3))
                0:       put_text($sformatf("%0d", MODIF_CTRL + 1));
                1:       put_text($sformatf("%0d", MODIF_CTRL_SHIFT + 1));
                2:       put_text($sformatf("%0d", $urandom_range(300)));
                default: ;
            endcase
        end else if (form >= 8) begin
            // junk parameters, often longer than what the decoder keeps
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                if (form == 8) begin
                    b = 8'($urandom_range(8'h20, 8'h3F));
                end else begin
                    do b = 8'($urandom); while (b >= FINAL_LO && b <= FINAL_HI);
                end
                put_byte(b);
            end
        end
        if (cut) put_tmo();
        else if ($urandom_range(4) != 0) put_byte(finals[$urandom_range(5)]);
        else put_byte(8'($urandom_range(FINAL_LO, FINAL_HI)));
    endfunction

    function automatic void add_random_item();
        int sel;
        logic [7:0] b;
        sel = $urandom_range(99);
        if (sel < 18) begin
            do b = 8'($urandom_range(8'h7F)); while (b == ESC_BYTE);
            put_byte(b);
        end else if (sel < 36) begin
            add_utf8($urandom_range(2, 4), 1'b0, 1'b0);
        end else if (sel < 66) begin
            add_esc_run(1'b0);
        end else if (sel < 74) begin
            if ($urandom_range(1)) add_utf8($urandom_range(2, 4), 1'b1, 1'b0);
            else add_utf8($urandom_range(2, 4), 1'b0, 1'b1);
        end else if (sel < 82) begin
            case ($urandom_range(2))
                0: begin
                    put_byte(ESC_BYTE);
                    put_tmo();
                end
                1: begin
                    put_byte(ESC_BYTE);
                    do b = 8'($urandom); while (b == CSI_INTRO || b == SS3_INTRO);
                    put_byte(b);
                end
                default: add_esc_run(1'b1);
            endcase
        end else if (sel < 90) begin
            put_tmo();
        end else begin
            put_byte(8'($urandom));
        end
    endfunction

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        t_beat nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                decode_beat(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_feed.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tuser  <= nxt.tmo;
                    beats_sent++;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            // idle profile: light sender / heavy stall, then swapped, then none
            if (beats_sent < n_beats / 3) begin
                send_idle_pct  = 33;
                recv_stall_pct <= 81;
            end else if (beats_sent < 2 * n_beats / 3) begin
                send_idle_pct  = 81;
                recv_stall_pct <= 33;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct <= 0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        t_key want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_keys.size() == 0) begin
                    bad_beats++;
                    $display({"%0t: unexpected key beat: expected none, ",
                              "got special=%0b data=%06h"},
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = pending_keys.pop_front();
                    if (m_axis_tuser !== want.special
                        || m_axis_tdata !== {3'b000, want.code}) begin
                        bad_beats++;
                        $display({"%0t: key mismatch: expected special=%0b code=%06h, ",
                                  "got special=%0b data=%06h"},
                                 $time, want.special, want.code,
                                 m_axis_tuser, m_axis_tdata);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        // directed: ASCII extremes, idle timeout, out-of-range code point,
        // bad continuation, timeout mid UTF-8, stray bytes, lone ESC,
        // wrong introducer, timeout in params, ctrl-shift modifier
        put_byte(8'h00);
        put_byte(8'h7F);
        put_tmo();
        put_byte(8'hF7); put_byte(8'hBF); put_byte(8'hBF); put_byte(8'hBF);
        put_byte(8'hC3); put_byte(8'h41);
        put_byte(8'hE2); put_byte(8'h82); put_tmo();
        put_byte(8'h80);
        put_byte(8'hFF);
        put_byte(ESC_BYTE); put_tmo();
        put_byte(ESC_BYTE); put_byte(8'h78);
        put_byte(ESC_BYTE); put_byte(CSI_INTRO); put_tmo();
        put_byte(ESC_BYTE); put_byte(CSI_INTRO);
        put_text($sformatf("%0d;%0d", VT_HOME, MODIF_CTRL_SHIFT + 1));
        put_byte(FIN_UP);

        while (byte_feed.size() < RANDOM_BEATS + 25) add_random_item();
        n_beats = byte_feed.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (byte_feed.size() != 0 || s_axis_tvalid || pending_keys.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bad_beats == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
